/* design/rsm_pkg.sv */
// shared constants and types for the rsa sign and verify unit
package rsm_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [1:0] REG_MODULUS  = 2'd0;
  localparam logic [1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIV_EXP = 2'd2;
  localparam int CFG_IDX_W = 2;

  localparam logic FUNC_SIGN   = 1'b0;
  localparam logic FUNC_VERIFY = 1'b1;

  localparam logic [WIDTH-1:0] MODULUS_RST  = WIDTH'(1022117);
  localparam logic [WIDTH-1:0] PUB_EXP_RST  = WIDTH'(65537);
  localparam logic [WIDTH-1:0] PRIV_EXP_RST = '0;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SQR    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // one cell step: r = 2r (+a) mod n, all below n
  typedef struct packed {
    logic [WIDTH-1:0] r;
    logic [WIDTH-1:0] a;
    logic             add;
  } cell_in_t;

  function automatic logic [WIDTH-1:0] add_mod(
    input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] n);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[WIDTH-1:0];
  endfunction

endpackage

/* design/rsm_if.sv */
// valid/ready channel carrying one word
interface rsm_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rsm_cell.sv */
// one modular shift-and-add cell of the multiplier chain
module rsm_cell (
  input  logic                          clk,
  input  logic [rsm_pkg::WIDTH-1:0]     n,
  input  logic                          en,
  input  rsm_pkg::cell_in_t             din,
  output rsm_pkg::cell_in_t             dout
);
  logic [rsm_pkg::WIDTH-1:0] dbl;
  logic [rsm_pkg::WIDTH-1:0] res;

  always_comb begin
    dbl = rsm_pkg::add_mod(din.r, din.r, n);
    res = din.add ? rsm_pkg::add_mod(dbl, din.a, n) : dbl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.r   <= res;
      dout.a   <= din.a;
      dout.add <= 1'b0;
    end
  end
endmodule

/* design/rsm_mulchain.sv */
// chain of cells forming a modular product, one multiplier bit per cycle
module rsm_mulchain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rsm_pkg::WIDTH-1:0] n,
  input  logic [rsm_pkg::WIDTH-1:0] a,
  input  logic [rsm_pkg::WIDTH-1:0] b,
  output logic                      done,
  output logic [rsm_pkg::WIDTH-1:0] prod
);
  localparam int NC = 2;
  localparam int STEPS = rsm_pkg::WIDTH / NC;

  logic [rsm_pkg::WIDTH-1:0] b_r;
  logic [rsm_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r, done_r, phase_r;
  rsm_pkg::cell_in_t         c0_in, c0_out, c1_in, c1_out;

  // cell 0 takes the even steps and cell 1 the odd ones; the partial product
  // loops round the pair, so one multiplier bit goes in per cycle
  assign c0_in.r   = (cnt_r == '0) ? '0 : c1_out.r;
  assign c0_in.a   = a;
  assign c0_in.add = b_r[rsm_pkg::WIDTH-1];

  rsm_cell u_c0 (.clk(clk), .n(n), .en(busy_r && !phase_r), .din(c0_in), .dout(c0_out));

  assign c1_in.r   = c0_out.r;
  assign c1_in.a   = c0_out.a;
  assign c1_in.add = b_r[rsm_pkg::WIDTH-1];

  rsm_cell u_c1 (.clk(clk), .n(n), .en(busy_r && phase_r), .din(c1_in), .dout(c1_out));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == rsm_pkg::CNT_W'(STEPS - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  // multiplier bits, top bit first
  always_ff @(posedge clk) begin
    if (start) begin
      b_r <= b;
    end else if (busy_r) begin
      b_r <= {b_r[rsm_pkg::WIDTH-2:0], 1'b0};
    end
  end

  assign prod = c1_out.r;
  assign done = done_r;
endmodule

/* design/rsa_sign_verify_modexp.sv */
// top level of the rsa sign and verify modular exponentiation unit
// Usage:
//  in (func, message_hash, signature) is taken when idle; one word out per word in.
//  func 0 signs: message_hash ^ private_exponent mod modulus, match 0.
//  func 1 verifies: signature ^ public_exponent mod modulus, match set when
//   the recovered value equals message_hash.
//  cfg writes index 0 modulus, 1 public exponent, 2 private exponent; other
//   indexes are dropped; write only while idle.
//  Sequence: one base reduction, then for each of 32 exponent bits a square
//   and, on a set bit, a multiply; each product runs through a chain of two
//   shift-and-add cells taking one multiplier bit per cycle. The next word is
//   taken only after the previous result has gone to the output register and
//   the unit is back in idle. With modulus zero no products are computed.
//  The next item is taken while the previous result waits in the output
//   register; a stalled receiver holds that result, and a finished next
//   result waits in the unit until the output register is free.
//  Reset restores the register defaults and empties the unit.
//  Modulus zero yields 0, modulus one yields 0.
module rsa_sign_verify_modexp (
  input logic clk,
  input logic rst_n,
  rsm_if.sink   in_ch,
  rsm_if.source out_ch,
  rsm_if.sink   cfg_ch
);
  localparam int W = rsm_pkg::WIDTH;

  logic [W-1:0] mod_r, pub_r, priv_r;
  logic [2:0]   st_r, st_nxt;
  logic [W-1:0] acc_r, base_r, exp_r, hash_r;
  logic         func_r;
  logic [rsm_pkg::CNT_W-1:0] bit_r;
  logic         out_valid_r;
  logic [W-1:0] out_val_r;
  logic         out_match_r;
  logic         mstart;
  logic [W-1:0] ma, mb;
  logic         mdone;
  logic [W-1:0] mprod;
  logic         in_fire;
  logic         zero_mod;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= rsm_pkg::MODULUS_RST;
      pub_r  <= rsm_pkg::PUB_EXP_RST;
      priv_r <= rsm_pkg::PRIV_EXP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data[W +: rsm_pkg::CFG_IDX_W])
        rsm_pkg::REG_MODULUS:  mod_r  <= cfg_ch.data[W-1:0];
        rsm_pkg::REG_PUB_EXP:  pub_r  <= cfg_ch.data[W-1:0];
        rsm_pkg::REG_PRIV_EXP: priv_r <= cfg_ch.data[W-1:0];
        default: ;
      endcase
    end
  end

  assign zero_mod = (mod_r == '0);
  assign in_ch.ready = (st_r == rsm_pkg::ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;

  // in data packing: {func, message_hash, signature}
  // base reduction uses base * 1 mod n in the chain
  always_comb begin
    ma = base_r;
    mb = '0;
    case (st_r)
      rsm_pkg::ST_REDUCE: begin ma = W'(1); mb = base_r; end
      rsm_pkg::ST_MUL:    begin ma = acc_r; mb = base_r; end
      rsm_pkg::ST_SQR:    begin ma = base_r; mb = base_r; end
      default: ;
    endcase
  end

  logic busy_mul_r;
  assign mstart = !busy_mul_r && ((st_r == rsm_pkg::ST_REDUCE) ||
                  (st_r == rsm_pkg::ST_MUL) || (st_r == rsm_pkg::ST_SQR));

  rsm_mulchain u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .n(mod_r),
                      .a(ma), .b(mb), .done(mdone), .prod(mprod));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rsm_pkg::ST_IDLE:   if (in_fire) st_nxt = zero_mod ? rsm_pkg::ST_DONE : rsm_pkg::ST_REDUCE;
      rsm_pkg::ST_REDUCE: if (mdone) st_nxt = exp_r[0] ? rsm_pkg::ST_MUL : rsm_pkg::ST_SQR;
      rsm_pkg::ST_MUL:    if (mdone) st_nxt = rsm_pkg::ST_SQR;
      rsm_pkg::ST_SQR: begin
        if (mdone) begin
          if (bit_r == rsm_pkg::CNT_W'(W - 1)) st_nxt = rsm_pkg::ST_DONE;
          else if (exp_r[1]) st_nxt = rsm_pkg::ST_MUL;
          else st_nxt = rsm_pkg::ST_SQR;
        end
      end
      rsm_pkg::ST_DONE:   if (!out_valid_r) st_nxt = rsm_pkg::ST_IDLE;
      default: st_nxt = rsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rsm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      busy_mul_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (mstart) busy_mul_r <= 1'b1;
      else if (mdone) busy_mul_r <= 1'b0;
      if (st_r == rsm_pkg::ST_DONE && !out_valid_r) out_valid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_ch.data[2*W];
      hash_r <= in_ch.data[2*W-1:W];
      base_r <= in_ch.data[2*W] ? in_ch.data[W-1:0] : in_ch.data[2*W-1:W];
      exp_r  <= in_ch.data[2*W] ? pub_r : priv_r;
      // 1 mod n: zero when n is one
      acc_r  <= (mod_r == W'(1)) ? '0 : W'(1);
      bit_r  <= '0;
    end else if (mdone) begin
      case (st_r)
        rsm_pkg::ST_REDUCE: base_r <= mprod;
        rsm_pkg::ST_MUL:    acc_r  <= mprod;
        rsm_pkg::ST_SQR: begin
          base_r <= mprod;
          exp_r  <= {1'b0, exp_r[W-1:1]};
          bit_r  <= bit_r + 1'b1;
        end
        default: ;
      endcase
    end
    if (st_r == rsm_pkg::ST_DONE && !out_valid_r) begin
      out_val_r   <= zero_mod ? '0 : acc_r;
      out_match_r <= (func_r == rsm_pkg::FUNC_VERIFY) &&
                     ((zero_mod ? '0 : acc_r) == hash_r);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = {out_val_r, out_match_r};

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (st_r == rsm_pkg::ST_IDLE)) else $error("ready while busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mstart |-> !busy_mul_r) else $error("multiplier restarted");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result lost");
endmodule
